FILE: rtl/core/vnev_pkg.sv
// Types, status codes, register indexes and a shift helper for the
// version node entry validator. No dependencies.
package vnev_pkg;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_COUNT     = 4'd1,
      ST_ZERO_GEN  = 4'd2,
      ST_NOT_INC   = 4'd3,
      ST_SAME      = 4'd4,
      ST_STRIDE    = 4'd5,
      ST_TOO_MANY  = 4'd6,
      ST_ROOT_LVL  = 4'd7,
      ST_STATS     = 4'd8,
      ST_SPAN      = 4'd9
   } status_type;

   localparam logic REG_ARITY  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [16:0] COUNT_SAT = 17'd65537;

   typedef logic [10:0] shift_type;

   typedef struct packed {
      logic [4:0] arity;
      logic [5:0] height;
   } cfg_type;

   // One classified entry as it travels from the front to the back.
   typedef struct packed {
      logic [63:0] gen;
      logic [63:0] gen_m1;
      logic [63:0] q_gen;
      logic [63:0] q_span;
      logic [63:0] leaf_min;
      status_type  leaf_code;
      logic        leaf;
      logic        last;
      logic        zero;
      logic        not_mult;
      logic        too_many;
      shift_type   s;
      shift_type   sa;
      logic [4:0]  a;
   } entry_type;

   typedef struct packed {
      status_type  status;
      logic [16:0] bad_index;
   } result_type;

   // Logical right shift in which a shift of 64 or more gives zero.
   function automatic logic [63:0] shr_sat(input logic [63:0] v, input shift_type n);
      logic [63:0] r;
      if (n >= shift_type'(64)) begin
         r = '0;
      end else begin
         r = v >> n[5:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/version_node_entry_validator_core.sv
// An accepted entry is written into the entry queue and checked by the back end once it
// reaches the head; the result of a final entry passes through the result queue to rsp_.
// Throughput: one entry per cycle while the result queue has room, set by the single back-end step per entry.
// Reset (synchronous): arity_log2 to 1, node_height to 0, both queues emptied and the
// per-node state cleared; there is no clearing pass.
// Depends on vnev_pkg, vnev_front, vnev_back and vnev_fifo.
module version_node_entry_validator_core import vnev_pkg::*; #(
   parameter int MAX_ARITY_LOG2 = 16,
   parameter int QUEUE_DEPTH    = 2
) (
   input  logic        clock,
   input  logic        reset,
   // Entry channel.
   input  logic        push,
   output logic        full,
   input  logic [63:0] req_generation,
   input  logic [63:0] req_child_generations,
   input  logic        req_root_absent,
   input  logic [7:0]  req_root_level,
   input  logic        req_stats_nonzero,
   input  logic        req_last_entry,
   // Result channel.
   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_status,
   output logic [16:0] rsp_bad_index,
   // Register write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata
);

   // The configuration registers. They are sampled by the front end as each
   // beat arrives, so every entry carries the settings that stood at its arrival.
   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ARITY:  cfg_in.arity  = csr_wdata[4:0];
            REG_HEIGHT: cfg_in.height = csr_wdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.arity  <= 5'd1;
         cfg_ff.height <= 6'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end is pure classification: everything that depends only on
   // the entry and the configuration (shifted quotients, stride and leaf checks).
   entry_type front_pkt;

   vnev_front #(
      .MAX_ARITY_LOG2(MAX_ARITY_LOG2)
   ) u_front (
      .cfg              (cfg_ff),
      .generation       (req_generation),
      .child_generations(req_child_generations),
      .root_absent      (req_root_absent),
      .root_level       (req_root_level),
      .stats_nonzero    (req_stats_nonzero),
      .last_entry       (req_last_entry),
      .pkt              (front_pkt)
   );

   // A short queue decouples the front end from the back end, so an input beat
   // is taken even while the back end waits for room for a result.
   logic [$bits(entry_type)-1:0] entry_rd;
   logic                         entry_empty;
   logic                         entry_pop;
   entry_type                    back_pkt;

   vnev_fifo #(
      .WIDTH($bits(entry_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_entry_q (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_data(front_pkt),
      .full   (full),
      .pop    (entry_pop),
      .rd_data(entry_rd),
      .empty  (entry_empty)
   );

   assign back_pkt = entry_type'(entry_rd);

   // The back end holds the per-node state and decides the result at the
   // final entry of each node.
   result_type back_res;
   logic       res_push;
   logic       res_full;

   vnev_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pkt      (back_pkt),
      .pkt_valid(!entry_empty),
      .pkt_pop  (entry_pop),
      .res_full (res_full),
      .res_push (res_push),
      .res      (back_res)
   );

   // The result queue: its head is what the rsp_ ports show.
   logic [$bits(result_type)-1:0] res_rd;
   result_type                    res_head;

   vnev_fifo #(
      .WIDTH($bits(result_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_result_q (
      .clock  (clock),
      .reset  (reset),
      .push   (res_push),
      .wr_data(back_res),
      .full   (res_full),
      .pop    (pop),
      .rd_data(res_rd),
      .empty  (empty)
   );

   assign res_head      = result_type'(res_rd);
   assign rsp_status    = res_head.status;
   assign rsp_bad_index = res_head.bad_index;

`ifndef SYNTHESIS
   // An index is only reported with a per-entry error.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_status == ST_OK || rsp_status == ST_COUNT || rsp_status == ST_SPAN))
      |-> (rsp_bad_index == 17'd0))
      else $error("bad_index set for a status without an entry");

   // A reported failing entry lies within a node of legal size.
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_bad_index < 17'd65536))
      else $error("bad_index beyond the largest node");

   // Status codes stay within the defined set.
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_status <= ST_SPAN))
      else $error("undefined status code");

   // Reset leaves no result waiting.
   assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("result present straight after reset");
`endif

endmodule

FILE: rtl/core/vnev_fifo.sv
// Small first-in first-out queue built from registers.
// Generic; no package dependencies.
module vnev_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/core/vnev_front.sv
// Front end: classifies one entry against the configuration alone.
// Depends on vnev_pkg.
module vnev_front import vnev_pkg::*; #(
   parameter int MAX_ARITY_LOG2 = 16
) (
   input  cfg_type     cfg,
   input  logic [63:0] generation,
   input  logic [63:0] child_generations,
   input  logic        root_absent,
   input  logic [7:0]  root_level,
   input  logic        stats_nonzero,
   input  logic        last_entry,
   output entry_type   pkt
);

   logic [4:0]  a;
   shift_type   s;
   logic [63:0] gen_m1;
   logic [63:0] stride_mask;
   logic [63:0] stride;
   logic [63:0] arity_mask;

   always_comb begin
      if (cfg.arity == 5'd0) begin
         a = 5'd1;
      end else if (cfg.arity > 5'(MAX_ARITY_LOG2)) begin
         a = 5'(MAX_ARITY_LOG2);
      end else begin
         a = cfg.arity;
      end
   end

   assign s           = shift_type'(a) * shift_type'(cfg.height);
   assign gen_m1      = generation - 64'd1;
   assign stride      = 64'd1 << s[5:0];
   assign stride_mask = stride - 64'd1;
   assign arity_mask  = (64'd1 << a) - 64'd1;

   always_comb begin
      pkt          = '0;
      pkt.gen      = generation;
      pkt.gen_m1   = gen_m1;
      pkt.q_gen    = shr_sat(gen_m1, s);
      pkt.q_span   = shr_sat(gen_m1, s + shift_type'(a));
      pkt.leaf_min = generation - (gen_m1 & arity_mask);
      pkt.leaf     = (cfg.height == 6'd0);
      pkt.last     = last_entry;
      pkt.zero     = (generation == 64'd0);
      pkt.not_mult = (s >= shift_type'(64)) || ((generation & stride_mask) != 64'd0);
      pkt.too_many = (s < shift_type'(64)) && (child_generations > stride);
      pkt.s        = s;
      pkt.sa       = s + shift_type'(a);
      pkt.a        = a;
      if (root_absent && root_level != 8'd0) begin
         pkt.leaf_code = ST_ROOT_LVL;
      end else if (root_absent && stats_nonzero) begin
         pkt.leaf_code = ST_STATS;
      end else begin
         pkt.leaf_code = ST_OK;
      end
   end

endmodule

FILE: rtl/core/vnev_back.sv
// Back end: checks entries against the stored node state and forms the
// per-node result. Depends on vnev_pkg.
module vnev_back import vnev_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  pkt,
   input  logic       pkt_valid,
   output logic       pkt_pop,
   input  logic       res_full,
   output logic       res_push,
   output result_type res
);

   logic [63:0] prev_ff, prev_in;
   logic [63:0] prev_m1_ff, prev_m1_in;
   logic [63:0] first_ff, first_in;
   logic [63:0] first_m1_ff, first_m1_in;
   logic [16:0] count_ff, count_in;
   status_type  err_ff, err_in;
   logic [16:0] err_idx_ff, err_idx_in;

   logic        fire;
   logic        has_prev;
   logic        not_inc;
   logic        same_child;
   status_type  code;
   logic [16:0] count_nx;
   status_type  err_nx;
   logic [16:0] err_idx_nx;
   logic [63:0] first_sel;
   logic [63:0] first_m1_sel;
   logic        span_bad;
   logic [16:0] limit;

   // A non-final entry never needs the result queue.
   assign fire     = pkt_valid && (!pkt.last || !res_full);
   assign pkt_pop  = fire;
   assign res_push = fire && pkt.last;

   assign has_prev   = (count_ff != 17'd0);
   assign not_inc    = has_prev && (pkt.gen <= prev_ff);
   assign same_child = has_prev && (pkt.q_gen == shr_sat(prev_m1_ff, pkt.s));

   always_comb begin
      if (pkt.leaf) begin
         if (pkt.leaf_code != ST_OK) begin
            code = pkt.leaf_code;
         end else if (pkt.zero) begin
            code = ST_ZERO_GEN;
         end else if (not_inc) begin
            code = ST_NOT_INC;
         end else begin
            code = ST_OK;
         end
      end else begin
         if (pkt.zero) begin
            code = ST_ZERO_GEN;
         end else if (not_inc) begin
            code = ST_NOT_INC;
         end else if (same_child) begin
            code = ST_SAME;
         end else if (pkt.not_mult) begin
            code = ST_STRIDE;
         end else if (pkt.too_many) begin
            code = ST_TOO_MANY;
         end else begin
            code = ST_OK;
         end
      end
   end

   assign count_nx     = (count_ff < COUNT_SAT) ? count_ff + 17'd1 : count_ff;
   assign err_nx       = (err_ff != ST_OK) ? err_ff : code;
   assign err_idx_nx   = (err_ff != ST_OK) ? err_idx_ff : count_ff;
   assign first_sel    = has_prev ? first_ff : pkt.gen;
   assign first_m1_sel = has_prev ? first_m1_ff : pkt.gen_m1;
   assign limit        = 17'd1 << pkt.a;

   always_comb begin
      if (pkt.leaf) begin
         span_bad = (first_sel < pkt.leaf_min);
      end else begin
         span_bad = (pkt.q_span != shr_sat(first_m1_sel, pkt.sa));
      end
   end

   always_comb begin
      res = '0;
      if (count_nx > limit) begin
         res.status = ST_COUNT;
      end else if (err_nx != ST_OK) begin
         res.status    = err_nx;
         res.bad_index = err_idx_nx;
      end else if (span_bad) begin
         res.status = ST_SPAN;
      end else begin
         res.status = ST_OK;
      end
   end

   always_comb begin
      prev_in     = prev_ff;
      prev_m1_in  = prev_m1_ff;
      first_in    = first_ff;
      first_m1_in = first_m1_ff;
      count_in    = count_ff;
      err_in      = err_ff;
      err_idx_in  = err_idx_ff;
      if (fire) begin
         if (pkt.last) begin
            prev_in     = '0;
            prev_m1_in  = '0;
            first_in    = '0;
            first_m1_in = '0;
            count_in    = '0;
            err_in      = ST_OK;
            err_idx_in  = '0;
         end else begin
            prev_in     = pkt.gen;
            prev_m1_in  = pkt.gen_m1;
            first_in    = first_sel;
            first_m1_in = first_m1_sel;
            count_in    = count_nx;
            err_in      = err_nx;
            err_idx_in  = (err_nx != ST_OK) ? err_idx_nx : 17'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         err_ff     <= ST_OK;
         err_idx_ff <= '0;
      end else begin
         count_ff   <= count_in;
         err_ff     <= err_in;
         err_idx_ff <= err_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff     <= prev_in;
      prev_m1_ff  <= prev_m1_in;
      first_ff    <= first_in;
      first_m1_ff <= first_m1_in;
   end

endmodule

FILE: tb/vnev_checker.sv
// Scoreboard for the version node entry validator: it watches the entry, result and
// register channels, predicts each node verdict and compares it with the result beat.
// Depends on vnev_pkg.
module vnev_checker import vnev_pkg::*; #(
   parameter int MAX_ARITY_LOG2 = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [63:0] req_generation,
   input  logic [63:0] req_child_generations,
   input  logic        req_root_absent,
   input  logic [7:0]  req_root_level,
   input  logic        req_stats_nonzero,
   input  logic        req_last_entry,
   input  logic        empty,
   input  logic        pop,
   input  logic [3:0]  rsp_status,
   input  logic [16:0] rsp_bad_index,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata,
   output int          mismatches,
   output int          pending
);

   localparam int unsigned COUNT_LIMIT = 65537;

   logic [4:0]   arity_reg;
   logic [5:0]   height_reg;
   logic [63:0]  last_gen;
   logic [63:0]  first_gen;
   int unsigned  seen_count;
   status_type   fault_code;
   logic [16:0]  fault_index;
   result_type   awaited_verdicts[$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   function automatic logic [63:0] drop_bits(input logic [63:0] v, input int unsigned n);
      return (n >= 64) ? 64'd0 : (v >> n);
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic forget_node();
      last_gen    = '0;
      first_gen   = '0;
      seen_count  = 0;
      fault_code  = ST_OK;
      fault_index = '0;
   endtask

   task automatic judge_entry();
      int unsigned a;
      int unsigned h;
      int unsigned s;
      int unsigned idx;
      status_type  code;
      result_type  verdict;
      logic [63:0] g;
      logic [63:0] lowest;
      a = arity_reg;
      if (a < 1) a = 1;
      if (a > MAX_ARITY_LOG2) a = MAX_ARITY_LOG2;
      h    = height_reg;
      s    = a * h;
      idx  = seen_count;
      g    = req_generation;
      code = ST_OK;
      if (h == 0) begin
         if (req_root_absent) begin
            if (req_root_level != 8'd0) code = ST_ROOT_LVL;
            else if (req_stats_nonzero) code = ST_STATS;
         end
         if (code == ST_OK && g == 64'd0) code = ST_ZERO_GEN;
         if (code == ST_OK && idx > 0 && g <= last_gen) code = ST_NOT_INC;
      end else begin
         if (g == 64'd0) begin
            code = ST_ZERO_GEN;
         end else if (idx > 0 && g <= last_gen) begin
            code = ST_NOT_INC;
         end else if (idx > 0 &&
                      drop_bits(g - 64'd1, s) == drop_bits(last_gen - 64'd1, s)) begin
            code = ST_SAME;
         end else if (s >= 64 || (g & ((64'd1 << s) - 64'd1)) != 64'd0) begin
            code = ST_STRIDE;
         end else if (req_child_generations > (64'd1 << s)) begin
            code = ST_TOO_MANY;
         end
      end
      if (code != ST_OK && fault_code == ST_OK) begin
         fault_code  = code;
         fault_index = idx[16:0];
      end
      if (idx == 0) first_gen = g;
      last_gen = g;
      if (seen_count < COUNT_LIMIT) seen_count++;
      if (req_last_entry) begin
         verdict.bad_index = '0;
         if (seen_count > (32'd1 << a)) begin
            verdict.status = ST_COUNT;
         end else if (fault_code != ST_OK) begin
            verdict.status    = fault_code;
            verdict.bad_index = fault_index;
         end else begin
            verdict.status = ST_OK;
            if (h == 0) begin
               lowest = g - ((g - 64'd1) & ((64'd1 << a) - 64'd1));
               if (first_gen < lowest) verdict.status = ST_SPAN;
            end else if (drop_bits(drop_bits(g - 64'd1, s), a) !=
                         drop_bits(drop_bits(first_gen - 64'd1, s), a)) begin
               verdict.status = ST_SPAN;
            end
         end
         awaited_verdicts.push_back(verdict);
         forget_node();
      end
   endtask

   task automatic match_verdict();
      result_type want;
      if (awaited_verdicts.size() == 0) begin
         report_mismatch($sformatf("unexpected result beat, status %0d", rsp_status));
      end else begin
         want = awaited_verdicts.pop_front();
         if (rsp_status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
         if (rsp_bad_index !== want.bad_index)
            report_mismatch($sformatf("bad_index %0d, expected %0d",
                                      rsp_bad_index, want.bad_index));
      end
   endtask

   // An entry sees the registers as they stood before a write at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         arity_reg  = 5'd1;
         height_reg = 6'd0;
         forget_node();
         awaited_verdicts.delete();
      end else begin
         if (pop && !empty) match_verdict();
         if (push && !full) judge_entry();
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ARITY) arity_reg = csr_wdata[4:0];
            else height_reg = csr_wdata;
         end
      end
      pending <= awaited_verdicts.size();
   end

endmodule

FILE: tb/tb_version_node_entry_validator_core.sv
// Top of the version node entry validator testbench: clock, reset, stimulus and verdict.
// Depends on vnev_pkg, version_node_entry_validator_core and vnev_checker.
module tb_version_node_entry_validator_core import vnev_pkg::*; ();

   // The random part stops once this many entries have gone in; idling stops a little
   // earlier so that the tail of the run streams at full rate.
   localparam int unsigned ITEM_TARGET = 1850;
   localparam int unsigned QUIET_FROM  = 1650;

   typedef struct packed {
      logic [63:0] gen;
      logic [63:0] kids;
      logic        absent;
      logic [7:0]  level;
      logic        stats;
   } stim_entry_type;

   typedef enum int {NODE_CLEAN, NODE_BROKEN, NODE_NOISE} node_kind_type;

   typedef enum int {
      MUT_ZERO, MUT_RANDOM, MUT_REPEAT, MUT_NUDGE,
      MUT_KIDS, MUT_ROOT, MUT_OVERSIZE, MUT_SPAN
   } mutation_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic [63:0] req_generation = '0;
   logic [63:0] req_child_generations = '0;
   logic        req_root_absent = 1'b0;
   logic [7:0]  req_root_level = '0;
   logic        req_stats_nonzero = 1'b0;
   logic        req_last_entry = 1'b0;
   logic        pop = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_index = REG_ARITY;
   logic [5:0]  csr_wdata = '0;
   logic        full;
   logic        empty;
   logic [3:0]  rsp_status;
   logic [16:0] rsp_bad_index;
   logic        csr_ready;
   int          mismatches;
   int          pending;

   // Mirror of the registers as written, used only to shape well-formed nodes.
   logic [4:0]  cfg_arity = 5'd1;
   logic [5:0]  cfg_height = 6'd0;

   bit             quiet = 1'b0;
   int unsigned    sent = 0;
   stim_entry_type node_buf[$];
   int unsigned    pick;
   int unsigned    node_total;
   node_kind_type  kind;

   always #4 clock = ~clock;

   version_node_entry_validator_core i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_generation        (req_generation),
      .req_child_generations (req_child_generations),
      .req_root_absent       (req_root_absent),
      .req_root_level        (req_root_level),
      .req_stats_nonzero     (req_stats_nonzero),
      .req_last_entry        (req_last_entry),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_status            (rsp_status),
      .rsp_bad_index         (rsp_bad_index),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   vnev_checker i_checker (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_generation        (req_generation),
      .req_child_generations (req_child_generations),
      .req_root_absent       (req_root_absent),
      .req_root_level        (req_root_level),
      .req_stats_nonzero     (req_stats_nonzero),
      .req_last_entry        (req_last_entry),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_status            (rsp_status),
      .rsp_bad_index         (rsp_bad_index),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .mismatches            (mismatches),
      .pending               (pending)
   );

   // A hung block or a lost result ends here.
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic stim_entry_type make_entry(input logic [63:0] gen,
                                                 input logic [63:0] kids,
                                                 input logic absent, input logic [7:0] level,
                                                 input logic stats);
      stim_entry_type e;
      e.gen    = gen;
      e.kids   = kids;
      e.absent = absent;
      e.level  = level;
      e.stats  = stats;
      return e;
   endfunction

   // The result side stalls in bursts of random length, between stretches of
   // steady popping. Once the run goes quiet it pops at every edge.
   initial begin
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            pop <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Offers one entry beat, sometimes after a short idle burst, and returns at the edge
   // that accepts it. Push is left high so that back-to-back beats carry no gap.
   task automatic send_entry(input stim_entry_type e, input bit last);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      push                  <= 1'b1;
      req_generation        <= e.gen;
      req_child_generations <= e.kids;
      req_root_absent       <= e.absent;
      req_root_level        <= e.level;
      req_stats_nonzero     <= e.stats;
      req_last_entry        <= last;
      @(posedge clock);
      while (full) @(posedge clock);
      sent++;
   endtask

   task automatic send_node();
      for (int i = 0; i < node_buf.size(); i++)
         send_entry(node_buf[i], i == node_buf.size() - 1);
   endtask

   // Stops the entry side and waits until every predicted verdict has been popped. A
   // node still open in the block gives no result, so the task then waits on to let its
   // last entry clear the entry queue before the registers are touched.
   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [5:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_ARITY) cfg_arity = data[4:0];
      else cfg_height = data;
   endtask

   // Builds one node into node_buf. A clean node places its generations on distinct
   // stride multiples inside one node span, so it gets past every per-entry check and
   // reaches the span check. A broken node spoils one thing in a clean one; a noise node
   // is random throughout.
   task automatic build_node(input node_kind_type flavour);
      int unsigned    a;
      int unsigned    s;
      int unsigned    slots;
      int unsigned    n;
      int unsigned    cap;
      int unsigned    j;
      int unsigned    room;
      int unsigned    gap;
      int unsigned    victim;
      int             w;
      logic [63:0]    base;
      logic [63:0]    maxm;
      stim_entry_type e;
      mutation_type   how;
      a = cfg_arity;
      if (a < 1) a = 1;
      if (a > 16) a = 16;
      s = a * cfg_height;
      node_buf.delete();
      if (flavour == NODE_NOISE || s >= 64) begin
         // A stride of 2^64 or more admits no clean node at all.
         n = $urandom_range(1, 6);
         repeat (n) begin
            e.gen    = $urandom_range(0, 1) ? rand64() : (rand64() >> $urandom_range(40, 63));
            e.kids   = rand64();
            e.absent = 1'($urandom);
            e.level  = $urandom_range(0, 1) ? 8'd0 : 8'($urandom);
            e.stats  = 1'($urandom);
            node_buf.push_back(e);
         end
      end else begin
         // Generations are ((base << a) + j) << s with j in 1..slots; base is kept
         // narrow enough that nothing overflows 64 bits.
         w = 64 - int'(s) - int'(a);
         if (w >= 1) begin
            base  = rand64() >> (65 - w);
            slots = 32'd1 << a;
         end else begin
            base  = '0;
            maxm  = {64{1'b1}} >> s;
            slots = maxm[31:0];
         end
         cap = (slots < 8) ? slots : 8;
         if ($urandom_range(0, 7) == 0) cap = (slots < 48) ? slots : 48;
         n = $urandom_range(1, cap);
         j = 0;
         for (int i = 0; i < n; i++) begin
            room = slots - j - (n - i);
            if (room == 0) gap = 0;
            else if ($urandom_range(0, 3) == 0) gap = $urandom_range(0, room);
            else gap = $urandom_range(0, (room < 2) ? room : 2);
            j = j + 1 + gap;
            e.gen = ((base << a) + 64'(j)) << s;
            if (cfg_height == 6'd0) begin
               e.kids   = rand64();
               e.absent = 1'($urandom);
               e.level  = e.absent ? 8'd0 : 8'($urandom);
               e.stats  = e.absent ? 1'b0 : 1'($urandom);
            end else begin
               e.kids   = ($urandom_range(0, 4) == 0) ? (64'd1 << s) : (rand64() >> (64 - s));
               e.absent = 1'($urandom);
               e.level  = 8'($urandom);
               e.stats  = 1'($urandom);
            end
            node_buf.push_back(e);
         end
         if (flavour == NODE_BROKEN) begin
            how    = mutation_type'($urandom_range(0, 7));
            victim = $urandom_range(0, node_buf.size() - 1);
            if (how == MUT_SPAN) victim = node_buf.size() - 1;
            e = node_buf[victim];
            case (how)
               MUT_ZERO: begin
                  e.gen = '0;
               end
               MUT_RANDOM: begin
                  e.gen = rand64();
               end
               MUT_REPEAT: begin
                  if (victim > 0) e.gen = node_buf[victim - 1].gen;
                  else e.gen = rand64() >> $urandom_range(0, 63);
               end
               MUT_NUDGE: begin
                  e.gen = e.gen + 64'd1;
               end
               MUT_KIDS: begin
                  e.kids = (64'd1 << s) + 64'd1 + 64'($urandom_range(0, 3));
               end
               MUT_ROOT: begin
                  e.absent = 1'b1;
                  if ($urandom_range(0, 1) == 0) begin
                     e.level = 8'($urandom_range(1, 255));
                  end else begin
                     e.level = 8'd0;
                     e.stats = 1'b1;
                  end
               end
               MUT_SPAN: begin
                  e.gen = e.gen + ((64'd1 << s) << a);
               end
               default: begin
               end
            endcase
            node_buf[victim] = e;
            // Overfilling only makes sense where the fan-out is small.
            if (how == MUT_OVERSIZE && a <= 4) begin
               while (node_buf.size() <= (32'd1 << a) + $urandom_range(0, 1)) begin
                  e     = node_buf[node_buf.size() - 1];
                  e.gen = e.gen + (64'd1 << s);
                  node_buf.push_back(e);
               end
            end
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed nodes, leaf mode with the reset arity of 1 first.
      node_buf = '{make_entry(64'd1, 64'd0, 1'b1, 8'd0, 1'b0)};
      send_node();
      // All-ones generation and child count with every leaf flag set but absence.
      node_buf = '{make_entry({64{1'b1}}, {64{1'b1}}, 1'b0, 8'hFF, 1'b1)};
      send_node();
      // Missing root with a non-zero root height.
      node_buf = '{make_entry(64'd7, 64'd0, 1'b1, 8'h80, 1'b0)};
      send_node();
      // Missing root with non-zero statistics, on the second entry.
      node_buf = '{make_entry(64'd5, 64'd0, 1'b0, 8'd0, 1'b0),
                   make_entry(64'd6, 64'd0, 1'b1, 8'd0, 1'b1)};
      send_node();
      // A zero generation followed by a neighbour that wraps on the difference.
      node_buf = '{make_entry(64'd0, 64'd0, 1'b0, 8'd0, 1'b0),
                   make_entry({64{1'b1}}, 64'd0, 1'b0, 8'd0, 1'b0)};
      send_node();
      // Three entries against a fan-out of two: count wins over the ordering error.
      node_buf = '{make_entry(64'd3, 64'd0, 1'b0, 8'd0, 1'b0),
                   make_entry(64'd2, 64'd0, 1'b0, 8'd0, 1'b0),
                   make_entry(64'd4, 64'd0, 1'b0, 8'd0, 1'b0)};
      send_node();
      // Generations 2 and 3 straddle two leaf spans.
      node_buf = '{make_entry(64'd2, 64'd0, 1'b0, 8'd0, 1'b0),
                   make_entry(64'd3, 64'd0, 1'b0, 8'd0, 1'b0)};
      send_node();

      // Arity written as 0 behaves as 1; height 1 gives a stride of 2.
      write_reg(REG_ARITY, 6'd0);
      write_reg(REG_HEIGHT, 6'd1);
      node_buf = '{make_entry(64'd2, 64'd2, 1'b0, 8'd0, 1'b0),
                   make_entry(64'd4, 64'd0, 1'b0, 8'd0, 1'b0)};
      send_node();
      node_buf = '{make_entry(64'd2, 64'd3, 1'b0, 8'd0, 1'b0)};
      send_node();
      node_buf = '{make_entry(64'd3, 64'd0, 1'b0, 8'd0, 1'b0)};
      send_node();

      // Registers changed in the middle of a node: the second entry sees a stride of
      // 16 and lands in the same child as the first.
      write_reg(REG_ARITY, 6'd1);
      send_entry(make_entry(64'd8, 64'd0, 1'b0, 8'd0, 1'b0), 1'b0);
      write_reg(REG_HEIGHT, 6'd4);
      send_entry(make_entry(64'd9, 64'd0, 1'b0, 8'd0, 1'b0), 1'b1);
      // Interior node spanning two parent spans.
      node_buf = '{make_entry(64'd16, 64'd0, 1'b0, 8'd0, 1'b0),
                   make_entry(64'd48, 64'd0, 1'b0, 8'd0, 1'b0)};
      send_node();

      // Arity far above the maximum is clipped to 16.
      write_reg(REG_ARITY, 6'h3F);
      write_reg(REG_HEIGHT, 6'd0);
      node_buf = '{make_entry(64'd1, 64'd0, 1'b0, 8'd0, 1'b0),
                   make_entry(64'd65536, 64'd0, 1'b0, 8'd0, 1'b0)};
      send_node();
      // A stride of 2^64: every non-zero generation misses the stride.
      write_reg(REG_HEIGHT, 6'd4);
      node_buf = '{make_entry(64'h1_0000, 64'd0, 1'b0, 8'd0, 1'b0)};
      send_node();
      // The largest stride that still fits, with the child count right at it.
      write_reg(REG_ARITY, 6'd1);
      write_reg(REG_HEIGHT, 6'h3F);
      node_buf = '{make_entry(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                              1'b0, 8'd0, 1'b0)};
      send_node();

      // Random phases: new registers, then a run of nodes, mostly clean.
      while (sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) write_reg(REG_ARITY, $urandom_range(0, 1) ? 6'd0 : 6'd32);
         else if (pick == 1) write_reg(REG_ARITY, 6'($urandom_range(17, 63)));
         else if (pick < 7) write_reg(REG_ARITY, 6'($urandom_range(1, 4)));
         else if (pick < 9) write_reg(REG_ARITY, 6'($urandom_range(5, 16)));
         pick = $urandom_range(0, 9);
         if (pick < 5) write_reg(REG_HEIGHT, 6'd0);
         else if (pick < 8) write_reg(REG_HEIGHT, 6'($urandom_range(1, 3)));
         else if (pick == 8) write_reg(REG_HEIGHT, 6'($urandom_range(4, 63)));
         node_total = $urandom_range(2, 10);
         repeat (node_total) begin
            if (sent >= QUIET_FROM) quiet = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 7) kind = NODE_CLEAN;
            else if (pick < 9) kind = NODE_BROKEN;
            else kind = NODE_NOISE;
            build_node(kind);
            send_node();
         end
      end

      // Let the last verdicts come out, then wait on for anything stray.
      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: version_node_entry_validator_core.f
rtl/core/vnev_pkg.sv
rtl/core/vnev_fifo.sv
rtl/core/vnev_front.sv
rtl/core/vnev_back.sv
rtl/core/version_node_entry_validator_core.sv
tb/vnev_checker.sv
tb/tb_version_node_entry_validator_core.sv
